### rtl/cbss_pkg.sv
package cbss_pkg;

  // Default running coordinate width
  localparam int COORD_WIDTH_DEF = 32;

  // Fixed field widths
  localparam int FIELD_W  = 31;
  localparam int QOUT_W   = 32;
  localparam int TAG_W    = 8;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_ALIGN_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SPECIES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_SPECIES  = 2'd2;

  // Reset values of the configuration registers
  localparam logic [FIELD_W-1:0] MIN_ALIGN_RESET      = '0;
  localparam logic [TAG_W-1:0]   TARGET_SPECIES_RESET = 8'd0;
  localparam logic [TAG_W-1:0]   QUERY_SPECIES_RESET  = 8'd1;

  // Record kinds
  localparam logic ACT_HEADER = 1'b0;
  localparam logic ACT_BLOCK  = 1'b1;

  // One input record
  typedef struct packed {
    logic               action;
    logic [FIELD_W-1:0] target_start;
    logic [FIELD_W-1:0] target_stop;
    logic [FIELD_W-1:0] query_start;
    logic [FIELD_W-1:0] query_stop;
    logic [FIELD_W-1:0] query_size;
    logic               minus_strand;
    logic [FIELD_W-1:0] chain_number;
    logic [FIELD_W-1:0] match_len;
    logic [FIELD_W-1:0] target_gap;
    logic [FIELD_W-1:0] query_gap;
    logic               has_gaps;
  } in_item_t;

  // Geometry of one emitted segment
  typedef struct packed {
    logic [FIELD_W-1:0]       segment_chain;
    logic [FIELD_W-1:0]       segment_index;
    logic [FIELD_W-1:0]       target_begin;
    logic [FIELD_W-1:0]       target_end;
    logic signed [QOUT_W-1:0] query_begin;
    logic signed [QOUT_W-1:0] query_end;
    logic                     segment_minus;
    logic                     end_mismatch;
  } seg_result_t;

endpackage

### rtl/cbss_seg.sv
module cbss_seg #(
  parameter int COORD_WIDTH = cbss_pkg::COORD_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           go,
  input  cbss_pkg::in_item_t             item,
  input  logic [cbss_pkg::FIELD_W-1:0]   min_align_size,
  output logic                           emit,
  output cbss_pkg::seg_result_t          result
);

  localparam int CW = COORD_WIDTH;
  localparam int SW = cbss_pkg::FIELD_W + 2;

  // Chain state
  logic                         active_r, active_nxt;
  logic [CW-1:0]                rtb_r, rtb_nxt;
  logic [CW-1:0]                rte_r, rte_nxt;
  logic [CW-1:0]                rqb_r, rqb_nxt;
  logic [CW-1:0]                rqe_r, rqe_nxt;
  logic [CW-1:0]                exp_te_r, exp_te_nxt;
  logic [CW-1:0]                exp_qe_r, exp_qe_nxt;
  logic [CW-1:0]                qsize_r, qsize_nxt;
  logic                         minus_r, minus_nxt;
  logic [cbss_pkg::FIELD_W-1:0] chain_r, chain_nxt;
  logic [CW-1:0]                cnt_r, cnt_nxt;

  // Header span test on exact signed differences
  logic signed [SW-1:0] tspan, qspan, span;
  logic                 span_ok;

  assign tspan   = $signed({2'b00, item.target_stop}) - $signed({2'b00, item.target_start});
  assign qspan   = $signed({2'b00, item.query_stop}) - $signed({2'b00, item.query_start});
  assign span    = (tspan < qspan) ? tspan : qspan;
  assign span_ok = span >= $signed({2'b00, min_align_size});

  // Block arithmetic
  logic [CW-1:0] match_c, tgap_c, qgap_c;
  logic [CW-1:0] te1, qe1, tsum, qsum;
  logic [CW-1:0] qb_c, qend_c;
  logic          two_sided;

  assign match_c   = CW'(item.match_len);
  assign tgap_c    = item.has_gaps ? CW'(item.target_gap) : '0;
  assign qgap_c    = item.has_gaps ? CW'(item.query_gap) : '0;
  assign te1       = rte_r + match_c;
  assign qe1       = rqe_r + match_c;
  assign tsum      = te1 + tgap_c;
  assign qsum      = qe1 + qgap_c;
  assign two_sided = (item.target_gap != '0) && (item.query_gap != '0);

  // Query coordinates back on the forward strand
  assign qb_c   = minus_r ? (qsize_r - qe1) : rqb_r;
  assign qend_c = minus_r ? (qsize_r - rqb_r) : qe1;

  always_comb begin
    result.segment_chain = chain_r;
    result.segment_index = cbss_pkg::FIELD_W'(cnt_r);
    result.target_begin  = cbss_pkg::FIELD_W'(rtb_r);
    result.target_end    = cbss_pkg::FIELD_W'(te1);
    result.query_begin   = cbss_pkg::QOUT_W'(signed'(qb_c));
    result.query_end     = cbss_pkg::QOUT_W'(signed'(qend_c));
    result.segment_minus = minus_r;
    result.end_mismatch  = !item.has_gaps && ((te1 != exp_te_r) || (qe1 != exp_qe_r));
  end

  // Next state
  always_comb begin
    active_nxt = active_r;
    rtb_nxt    = rtb_r;
    rte_nxt    = rte_r;
    rqb_nxt    = rqb_r;
    rqe_nxt    = rqe_r;
    exp_te_nxt = exp_te_r;
    exp_qe_nxt = exp_qe_r;
    qsize_nxt  = qsize_r;
    minus_nxt  = minus_r;
    chain_nxt  = chain_r;
    cnt_nxt    = cnt_r;
    emit       = 1'b0;
    if (go) begin
      if (item.action == cbss_pkg::ACT_HEADER) begin
        active_nxt = span_ok && (item.chain_number != '0);
        cnt_nxt    = CW'(1);
        exp_te_nxt = CW'(item.target_stop);
        exp_qe_nxt = CW'(item.query_stop);
        if (span_ok && (item.chain_number != '0)) begin
          chain_nxt = item.chain_number;
          minus_nxt = item.minus_strand;
          qsize_nxt = CW'(item.query_size);
          rtb_nxt   = CW'(item.target_start);
          rte_nxt   = CW'(item.target_start);
          rqb_nxt   = CW'(item.query_start);
          rqe_nxt   = CW'(item.query_start);
        end
      end else if (active_r) begin
        rte_nxt = tsum;
        rqe_nxt = qsum;
        if (!item.has_gaps || two_sided) begin
          // segment closes here
          emit    = 1'b1;
          cnt_nxt = cnt_r + CW'(1);
          rtb_nxt = tsum;
          rqb_nxt = qsum;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      rtb_r    <= '0;
      rte_r    <= '0;
      rqb_r    <= '0;
      rqe_r    <= '0;
      exp_te_r <= '0;
      exp_qe_r <= '0;
      qsize_r  <= '0;
      minus_r  <= 1'b0;
      chain_r  <= '0;
      cnt_r    <= CW'(1);
    end else begin
      active_r <= active_nxt;
      rtb_r    <= rtb_nxt;
      rte_r    <= rte_nxt;
      rqb_r    <= rqb_nxt;
      rqe_r    <= rqe_nxt;
      exp_te_r <= exp_te_nxt;
      exp_qe_r <= exp_qe_nxt;
      qsize_r  <= qsize_nxt;
      minus_r  <= minus_nxt;
      chain_r  <= chain_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

### rtl/chain_block_segment_splitter.sv
// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall   one chain header or block record
// out_      output     out_valid/out_stall one closed segment
// cfg_      input      cfg_we              min size, target and query species
//
// One record per cycle sustained unless the output stalls. A record sits in the
// input register; as it leaves, the chain state and result register update, so a
// segment follows its closing block through both registers. Synchronous active-low
// reset clears the chain state and the valid flags. in_stall rises only while the
// input register holds a record and the result register is full and stalled.
module chain_block_segment_splitter #(
  parameter int COORD_WIDTH = cbss_pkg::COORD_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,

  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_action,
  input  logic [cbss_pkg::FIELD_W-1:0]     in_target_start,
  input  logic [cbss_pkg::FIELD_W-1:0]     in_target_stop,
  input  logic [cbss_pkg::FIELD_W-1:0]     in_query_start,
  input  logic [cbss_pkg::FIELD_W-1:0]     in_query_stop,
  input  logic [cbss_pkg::FIELD_W-1:0]     in_query_size,
  input  logic                             in_minus_strand,
  input  logic [cbss_pkg::FIELD_W-1:0]     in_chain_number,
  input  logic [cbss_pkg::FIELD_W-1:0]     in_match_len,
  input  logic [cbss_pkg::FIELD_W-1:0]     in_target_gap,
  input  logic [cbss_pkg::FIELD_W-1:0]     in_query_gap,
  input  logic                             in_has_gaps,

  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [cbss_pkg::FIELD_W-1:0]     out_segment_chain,
  output logic [cbss_pkg::FIELD_W-1:0]     out_segment_index,
  output logic [cbss_pkg::FIELD_W-1:0]     out_target_begin,
  output logic [cbss_pkg::FIELD_W-1:0]     out_target_end,
  output logic signed [cbss_pkg::QOUT_W-1:0] out_query_begin,
  output logic signed [cbss_pkg::QOUT_W-1:0] out_query_end,
  output logic                             out_segment_minus,
  output logic [cbss_pkg::TAG_W-1:0]       out_target_tag,
  output logic [cbss_pkg::TAG_W-1:0]       out_query_tag,
  output logic                             out_end_mismatch,

  input  logic                             cfg_we,
  input  logic [cbss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cbss_pkg::FIELD_W-1:0]     cfg_data
);

  // Configuration registers
  logic [cbss_pkg::FIELD_W-1:0] min_align_r;
  logic [cbss_pkg::TAG_W-1:0]   tspecies_r;
  logic [cbss_pkg::TAG_W-1:0]   qspecies_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_align_r <= cbss_pkg::MIN_ALIGN_RESET;
      tspecies_r  <= cbss_pkg::TARGET_SPECIES_RESET;
      qspecies_r  <= cbss_pkg::QUERY_SPECIES_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cbss_pkg::CFG_MIN_ALIGN_SIZE: min_align_r <= cfg_data;
        cbss_pkg::CFG_TARGET_SPECIES: tspecies_r  <= cfg_data[cbss_pkg::TAG_W-1:0];
        cbss_pkg::CFG_QUERY_SPECIES:  qspecies_r  <= cfg_data[cbss_pkg::TAG_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  cbss_pkg::in_item_t item_r;
  logic               item_valid_r;
  logic               advance;
  logic               take;

  assign advance  = !(out_valid && out_stall);
  assign in_stall = item_valid_r && !advance;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (!item_valid_r || advance) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.action       <= in_action;
      item_r.target_start <= in_target_start;
      item_r.target_stop  <= in_target_stop;
      item_r.query_start  <= in_query_start;
      item_r.query_stop   <= in_query_stop;
      item_r.query_size   <= in_query_size;
      item_r.minus_strand <= in_minus_strand;
      item_r.chain_number <= in_chain_number;
      item_r.match_len    <= in_match_len;
      item_r.target_gap   <= in_target_gap;
      item_r.query_gap    <= in_query_gap;
      item_r.has_gaps     <= in_has_gaps;
    end
  end

  // Segment datapath and chain state
  logic                  emit;
  cbss_pkg::seg_result_t seg;

  cbss_seg #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_seg (
    .clk           (clk),
    .rst_n         (rst_n),
    .go            (item_valid_r && advance),
    .item          (item_r),
    .min_align_size(min_align_r),
    .emit          (emit),
    .result        (seg)
  );

  // Result register
  logic                  out_valid_r;
  cbss_pkg::seg_result_t res_r;
  logic [cbss_pkg::TAG_W-1:0] ttag_r;
  logic [cbss_pkg::TAG_W-1:0] qtag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      res_r  <= seg;
      ttag_r <= tspecies_r;
      qtag_r <= qspecies_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_segment_chain = res_r.segment_chain;
  assign out_segment_index = res_r.segment_index;
  assign out_target_begin  = res_r.target_begin;
  assign out_target_end    = res_r.target_end;
  assign out_query_begin   = res_r.query_begin;
  assign out_query_end     = res_r.query_end;
  assign out_segment_minus = res_r.segment_minus;
  assign out_target_tag    = ttag_r;
  assign out_query_tag     = qtag_r;
  assign out_end_mismatch  = res_r.end_mismatch;

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import cbss_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam logic [FIELD_W-1:0] M31 = '1;

  // Expected segment, tags included
  typedef struct packed {
    logic [FIELD_W-1:0]       chain_id;
    logic [FIELD_W-1:0]       ordinal;
    logic [FIELD_W-1:0]       tgt_beg;
    logic [FIELD_W-1:0]       tgt_end;
    logic signed [QOUT_W-1:0] qry_beg;
    logic signed [QOUT_W-1:0] qry_end;
    logic                     minus;
    logic [TAG_W-1:0]         ttag;
    logic [TAG_W-1:0]         qtag;
    logic                     mismatch;
  } segment_t;

  // One directed stimulus row, optionally with a hand-written segment
  typedef struct {
    in_item_t rec;
    bit       pinned;
    segment_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic     in_valid = 1'b0;
  logic     in_stall;
  in_item_t drv = '0;
  logic     pin_valid = 1'b0;
  segment_t pin_seg = '0;

  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [FIELD_W-1:0]       out_segment_chain;
  logic [FIELD_W-1:0]       out_segment_index;
  logic [FIELD_W-1:0]       out_target_begin;
  logic [FIELD_W-1:0]       out_target_end;
  logic signed [QOUT_W-1:0] out_query_begin;
  logic signed [QOUT_W-1:0] out_query_end;
  logic                     out_segment_minus;
  logic [TAG_W-1:0]         out_target_tag;
  logic [TAG_W-1:0]         out_query_tag;
  logic                     out_end_mismatch;

  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_MIN_ALIGN_SIZE;
  logic [FIELD_W-1:0]   cfg_data = '0;

  // Register copies used for prediction
  logic [FIELD_W-1:0] min_span_cfg = MIN_ALIGN_RESET;
  logic [TAG_W-1:0]   tgt_species_cfg = TARGET_SPECIES_RESET;
  logic [TAG_W-1:0]   qry_species_cfg = QUERY_SPECIES_RESET;

  // Chain tracking state of the predictor
  bit            chain_on = 1'b0;
  logic [CW-1:0] run_tb = '0;
  logic [CW-1:0] run_te = '0;
  logic [CW-1:0] run_qb = '0;
  logic [CW-1:0] run_qe = '0;
  logic [CW-1:0] hdr_te = '0;
  logic [CW-1:0] hdr_qe = '0;
  logic [CW-1:0] q_len = '0;
  bit            on_minus = 1'b0;
  logic [CW-1:0] cur_chain = '0;
  logic [CW-1:0] seg_ord = 1;

  segment_t segments[$];
  segment_t got_seg, want_seg, pred_seg;
  int errors = 0;
  int n_xfer = 0;
  int n_checked = 0;
  int n_minus = 0;
  int n_flagged = 0;
  int n_cfg = 0;
  bit steady_in = 1'b0;

  always #5 clk = ~clk;

  chain_block_segment_splitter #(.COORD_WIDTH(CW)) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (drv.action),
    .in_target_start   (drv.target_start),
    .in_target_stop    (drv.target_stop),
    .in_query_start    (drv.query_start),
    .in_query_stop     (drv.query_stop),
    .in_query_size     (drv.query_size),
    .in_minus_strand   (drv.minus_strand),
    .in_chain_number   (drv.chain_number),
    .in_match_len      (drv.match_len),
    .in_target_gap     (drv.target_gap),
    .in_query_gap      (drv.query_gap),
    .in_has_gaps       (drv.has_gaps),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_segment_chain (out_segment_chain),
    .out_segment_index (out_segment_index),
    .out_target_begin  (out_target_begin),
    .out_target_end    (out_target_end),
    .out_query_begin   (out_query_begin),
    .out_query_end     (out_query_end),
    .out_segment_minus (out_segment_minus),
    .out_target_tag    (out_target_tag),
    .out_query_tag     (out_query_tag),
    .out_end_mismatch  (out_end_mismatch),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // Segment predictor: returns 1 when the record closes a segment
  function automatic bit split_record(input in_item_t r, output segment_t s);
    longint        tspan, qspan, shortest;
    logic [CW-1:0] tgap, qgap, qb_out, qe_out;
    bit            mism;
    s = '0;
    if (r.action == ACT_HEADER) begin
      tspan = longint'(r.target_stop) - longint'(r.target_start);
      qspan = longint'(r.query_stop) - longint'(r.query_start);
      shortest = (tspan < qspan) ? tspan : qspan;
      chain_on = 1'b0;
      seg_ord = 1;
      hdr_te = CW'(r.target_stop);
      hdr_qe = CW'(r.query_stop);
      if (shortest < longint'(min_span_cfg) || r.chain_number == 0) return 1'b0;
      chain_on = 1'b1;
      cur_chain = CW'(r.chain_number);
      on_minus = r.minus_strand;
      q_len = CW'(r.query_size);
      run_tb = CW'(r.target_start);
      run_te = run_tb;
      run_qb = CW'(r.query_start);
      run_qe = run_qb;
      return 1'b0;
    end
    if (!chain_on) return 1'b0;

    run_te = run_te + CW'(r.match_len);
    run_qe = run_qe + CW'(r.match_len);
    tgap = '0;
    qgap = '0;
    mism = 1'b0;
    if (r.has_gaps) begin
      tgap = CW'(r.target_gap);
      qgap = CW'(r.query_gap);
      // one-sided gap stays inside the segment
      if (tgap == 0 || qgap == 0) begin
        run_te = run_te + tgap;
        run_qe = run_qe + qgap;
        return 1'b0;
      end
    end else begin
      mism = (run_te != hdr_te) || (run_qe != hdr_qe);
    end

    // minus strand: mirror against query length, no clamping
    if (on_minus) begin
      qb_out = q_len - run_qe;
      qe_out = q_len - run_qb;
    end else begin
      qb_out = run_qb;
      qe_out = run_qe;
    end
    s.chain_id = cur_chain[FIELD_W-1:0];
    s.ordinal  = seg_ord[FIELD_W-1:0];
    s.tgt_beg  = run_tb[FIELD_W-1:0];
    s.tgt_end  = run_te[FIELD_W-1:0];
    s.qry_beg  = QOUT_W'($signed(qb_out));
    s.qry_end  = QOUT_W'($signed(qe_out));
    s.minus    = on_minus;
    s.ttag     = tgt_species_cfg;
    s.qtag     = qry_species_cfg;
    s.mismatch = mism;

    seg_ord = seg_ord + 1'b1;
    run_tb = run_te + tgap;
    run_qb = run_qe + qgap;
    run_te = run_tb;
    run_qe = run_qb;
    return 1'b1;
  endfunction

  task automatic note_field(input string what, input bit bad, input longint want,
                            input longint got);
    if (bad) begin
      $display("%0t  %s: expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  task automatic compare_segment(input segment_t want, input segment_t got);
    note_field("segment_chain", want.chain_id !== got.chain_id, want.chain_id, got.chain_id);
    note_field("segment_index", want.ordinal !== got.ordinal, want.ordinal, got.ordinal);
    note_field("target_begin", want.tgt_beg !== got.tgt_beg, want.tgt_beg, got.tgt_beg);
    note_field("target_end", want.tgt_end !== got.tgt_end, want.tgt_end, got.tgt_end);
    note_field("query_begin", want.qry_beg !== got.qry_beg,
               $signed(want.qry_beg), $signed(got.qry_beg));
    note_field("query_end", want.qry_end !== got.qry_end,
               $signed(want.qry_end), $signed(got.qry_end));
    note_field("segment_minus", want.minus !== got.minus, want.minus, got.minus);
    note_field("target_tag", want.ttag !== got.ttag, want.ttag, got.ttag);
    note_field("query_tag", want.qtag !== got.qtag, want.qtag, got.qtag);
    note_field("end_mismatch", want.mismatch !== got.mismatch, want.mismatch, got.mismatch);
  endtask

  // Monitor: check segments out, predict from records in
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got_seg.chain_id = out_segment_chain;
        got_seg.ordinal  = out_segment_index;
        got_seg.tgt_beg  = out_target_begin;
        got_seg.tgt_end  = out_target_end;
        got_seg.qry_beg  = out_query_begin;
        got_seg.qry_end  = out_query_end;
        got_seg.minus    = out_segment_minus;
        got_seg.ttag     = out_target_tag;
        got_seg.qtag     = out_query_tag;
        got_seg.mismatch = out_end_mismatch;
        if (segments.size() == 0) begin
          $display("%0t  segment with none pending: expected nothing, %s %0d index %0d",
                   $time, "actual chain", out_segment_chain, out_segment_index);
          errors++;
        end else begin
          want_seg = segments.pop_front();
          compare_segment(want_seg, got_seg);
          n_checked++;
          if (want_seg.minus) n_minus++;
          if (want_seg.mismatch) n_flagged++;
        end
      end
      if (in_valid && !in_stall) begin
        n_xfer++;
        if (split_record(drv, pred_seg))
          segments.insert(segments.size(), pin_valid ? pin_seg : pred_seg);
      end
    end
  end

  // Receiver stall: short bursts, a few long ones, and calm stretches
  initial begin : stall_gen
    int r;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(30, 150)) @(posedge clk);
      end else if (r < 55) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else if (r < 90) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(8, 30)) @(posedge clk);
      end
    end
  end

  function automatic logic [FIELD_W-1:0] rand_len();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return FIELD_W'($urandom);
    if (r < 3) return FIELD_W'($urandom_range(0, 65535));
    return FIELD_W'($urandom_range(0, 100));
  endfunction

  // Header record; block fields carry noise
  function automatic in_item_t hdr(input logic [FIELD_W-1:0] ts, te, qs, qe, qsz,
                                   input logic minus, input logic [FIELD_W-1:0] id);
    in_item_t r;
    r.action       = ACT_HEADER;
    r.target_start = ts;
    r.target_stop  = te;
    r.query_start  = qs;
    r.query_stop   = qe;
    r.query_size   = qsz;
    r.minus_strand = minus;
    r.chain_number = id;
    r.match_len    = FIELD_W'($urandom);
    r.target_gap   = FIELD_W'($urandom);
    r.query_gap    = FIELD_W'($urandom);
    r.has_gaps     = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // Block record; header fields carry noise
  function automatic in_item_t blk(input logic [FIELD_W-1:0] m, tg, qg, input logic gaps);
    in_item_t r;
    r.action       = ACT_BLOCK;
    r.target_start = FIELD_W'($urandom);
    r.target_stop  = FIELD_W'($urandom);
    r.query_start  = FIELD_W'($urandom);
    r.query_stop   = FIELD_W'($urandom);
    r.query_size   = FIELD_W'($urandom);
    r.minus_strand = 1'($urandom_range(0, 1));
    r.chain_number = FIELD_W'($urandom);
    r.match_len    = m;
    r.target_gap   = tg;
    r.query_gap    = qg;
    r.has_gaps     = gaps;
    return r;
  endfunction

  // Hand-written segment under the reset tags
  function automatic segment_t seg_of(input longint id, ord, tb, tend, qb, qend,
                                      input bit minus, mism);
    segment_t s;
    s.chain_id = FIELD_W'(id);
    s.ordinal  = FIELD_W'(ord);
    s.tgt_beg  = FIELD_W'(tb);
    s.tgt_end  = FIELD_W'(tend);
    s.qry_beg  = QOUT_W'(qb);
    s.qry_end  = QOUT_W'(qend);
    s.minus    = minus;
    s.ttag     = TARGET_SPECIES_RESET;
    s.qtag     = QUERY_SPECIES_RESET;
    s.mismatch = mism;
    return s;
  endfunction

  task automatic pause_input();
    int r, n;
    n = 0;
    r = $urandom_range(0, 19);
    if (!steady_in) begin
      if (r > 18) n = $urandom_range(15, 40);
      else if (r > 16) n = $urandom_range(4, 10);
      else if (r > 10) n = $urandom_range(1, 3);
    end
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Drive one record and hold it until its transfer
  task automatic push_record(input in_item_t r, input bit pinned, input segment_t s);
    drv <= r;
    in_valid <= 1'b1;
    pin_valid <= pinned;
    pin_seg <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Wait until every segment is back and the pipeline is empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (segments.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic program_regs(input logic [FIELD_W-1:0] min_v, tt_v, qt_v);
    cfg_we <= 1'b1;
    cfg_index <= CFG_MIN_ALIGN_SIZE;
    cfg_data <= min_v;
    @(posedge clk);
    cfg_index <= CFG_TARGET_SPECIES;
    cfg_data <= tt_v;
    @(posedge clk);
    cfg_index <= CFG_QUERY_SPECIES;
    cfg_data <= qt_v;
    @(posedge clk);
    cfg_we <= 1'b0;
    min_span_cfg = min_v;
    tgt_species_cfg = tt_v[TAG_W-1:0];
    qry_species_cfg = qt_v[TAG_W-1:0];
    n_cfg++;
  endtask

  // Well-formed chain with random content, sometimes corrupted or cut short
  task automatic send_chain(inout int done);
    in_item_t           body[$];
    in_item_t           h;
    logic [FIELD_W-1:0] m, tg, qg, ts, qs, te, qe, qsz, id;
    longint             tsum, qsum, need;
    int                 n, k;
    bit                 sym;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 16) : $urandom_range(1, 5);
    sym = ($urandom_range(0, 2) == 0);
    tsum = 0;
    qsum = 0;
    for (k = 1; k < n; k++) begin
      m = rand_len();
      tg = '0;
      qg = '0;
      case ($urandom_range(0, 3))
        1: tg = rand_len();
        2: qg = rand_len();
        3: begin
          tg = rand_len();
          qg = rand_len();
          if (tg == 0) tg = 1;
          if (qg == 0) qg = 1;
        end
        default: ;
      endcase
      if (sym) qg = tg;
      tsum = tsum + longint'(m) + longint'(tg);
      qsum = qsum + longint'(m) + longint'(qg);
      body.insert(body.size(), blk(m, tg, qg, 1'b1));
    end
    // last block stretched so the spans reach the minimum size
    m = rand_len();
    need = longint'(min_span_cfg) - ((tsum < qsum ? tsum : qsum) + longint'(m));
    if (need > 0) m = (longint'(m) + need > longint'(M31)) ? M31 : FIELD_W'(longint'(m) + need);
    body.insert(body.size(), blk(m, FIELD_W'($urandom), FIELD_W'($urandom), 1'b0));
    tsum = tsum + longint'(m);
    qsum = qsum + longint'(m);

    if (min_span_cfg > 31'h4000_0000) begin
      ts = '0;
      qs = '0;
    end else begin
      ts = rand_len() & 31'h3FFF_FFFF;
      qs = rand_len() & 31'h3FFF_FFFF;
    end
    te = FIELD_W'(longint'(ts) + tsum);
    qe = FIELD_W'(longint'(qs) + qsum);
    if ($urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 1)) te = te + FIELD_W'($urandom_range(1, 50));
      else qe = FIELD_W'($urandom);
    end
    case ($urandom_range(0, 2))
      0: qsz = qe + FIELD_W'($urandom_range(0, 1000));
      1: qsz = FIELD_W'($urandom);
      default: qsz = FIELD_W'($urandom_range(0, 100));
    endcase
    id = FIELD_W'($urandom);
    if (id == 0) id = 1;
    if ($urandom_range(0, 19) == 0) id = '0;
    h = hdr(ts, te, qs, qe, qsz, 1'($urandom_range(0, 1)), id);

    steady_in = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 19) == 0) void'(body.pop_back());
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(1, 2))
        body.insert(body.size(),
                    blk(rand_len(), rand_len(), rand_len(), 1'($urandom_range(0, 1))));
    end
    pause_input();
    push_record(h, 1'b0, '0);
    foreach (body[k]) begin
      pause_input();
      push_record(body[k], 1'b0, '0);
    end
    if (id != 0) done += 1 + body.size();
  endtask

  // Random phase: mostly chains, some stray blocks and raw noise
  task automatic run_phase(input int quota);
    in_item_t raw;
    int       done;
    done = 0;
    while (done < quota) begin
      case ($urandom_range(0, 49))
        0, 1, 2: begin
          steady_in = 1'b0;
          repeat ($urandom_range(1, 3)) begin
            pause_input();
            push_record(blk(rand_len(), rand_len(), rand_len(), 1'($urandom_range(0, 1))),
                        1'b0, '0);
          end
        end
        3: begin
          raw = hdr(FIELD_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom),
                    FIELD_W'($urandom), FIELD_W'($urandom), 1'($urandom_range(0, 1)),
                    FIELD_W'($urandom));
          raw.action = 1'($urandom_range(0, 1));
          pause_input();
          push_record(raw, 1'b0, '0);
        end
        default: send_chain(done);
      endcase
    end
  endtask

  // Main sequence
  initial begin : main_seq
    row_t plan[$];
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // plus strand, one-sided gaps absorbed, two-sided gap splits, final block
    plan.insert(plan.size(), '{hdr(100, 200, 10, 110, 1000, 1'b0, 5), 1'b0, '0});
    plan.insert(plan.size(), '{blk(40, 0, 7, 1'b1), 1'b0, '0});
    plan.insert(plan.size(), '{blk(10, 3, 0, 1'b1), 1'b0, '0});
    plan.insert(plan.size(), '{blk(20, 5, 6, 1'b1), 1'b1,
                               seg_of(5, 1, 100, 173, 10, 87, 0, 0)});
    plan.insert(plan.size(), '{blk(22, 9, 9, 1'b0), 1'b1,
                               seg_of(5, 2, 178, 200, 93, 115, 0, 1)});
    // block after the final block continues the chain
    plan.insert(plan.size(), '{blk(5, 0, 0, 1'b0), 1'b1,
                               seg_of(5, 3, 200, 205, 115, 120, 0, 1)});
    // minus strand, mirrored query goes negative
    plan.insert(plan.size(), '{hdr(0, 50, 0, 50, 30, 1'b1, 31'h7FFF_FFFF), 1'b0, '0});
    plan.insert(plan.size(), '{blk(20, 1, 1, 1'b1), 1'b1,
                               seg_of(31'h7FFF_FFFF, 1, 0, 20, 10, 30, 1, 0)});
    plan.insert(plan.size(), '{blk(29, 0, 0, 1'b0), 1'b1,
                               seg_of(31'h7FFF_FFFF, 2, 21, 50, -20, 9, 1, 0)});
    // zero id: chain inactive, blocks ignored
    plan.insert(plan.size(), '{hdr(0, 100, 0, 100, 100, 1'b0, 0), 1'b0, '0});
    plan.insert(plan.size(), '{blk(10, 0, 0, 1'b0), 1'b0, '0});
    // stop below start: negative span
    plan.insert(plan.size(), '{hdr(500, 100, 0, 1000, 1000, 1'b0, 9), 1'b0, '0});
    plan.insert(plan.size(), '{blk(7, 1, 1, 1'b1), 1'b0, '0});
    // zero span passes a zero minimum
    plan.insert(plan.size(), '{hdr(0, 0, 0, 0, 0, 1'b0, 3), 1'b0, '0});
    plan.insert(plan.size(), '{blk(0, 0, 0, 1'b0), 1'b1,
                               seg_of(3, 1, 0, 0, 0, 0, 0, 0)});
    // full-range coordinates, running ends wrap
    plan.insert(plan.size(), '{hdr(0, M31, 0, M31, M31, 1'b0, 1), 1'b0, '0});
    plan.insert(plan.size(), '{blk(M31, M31, 0, 1'b1), 1'b0, '0});
    plan.insert(plan.size(), '{blk(M31, M31, M31, 1'b1), 1'b0, '0});
    plan.insert(plan.size(), '{blk(0, 0, 0, 1'b0), 1'b0, '0});
    plan.insert(plan.size(), '{hdr(0, 10, 0, 10, M31, 1'b1, 2), 1'b0, '0});
    plan.insert(plan.size(), '{blk(10, 0, 0, 1'b0), 1'b0, '0});
    plan.insert(plan.size(), '{hdr(M31, M31, M31, M31, 0, 1'b1, 31'h2AAA_AAAA), 1'b0, '0});
    plan.insert(plan.size(), '{blk(M31, 0, 0, 1'b0), 1'b0, '0});
    foreach (plan[i]) begin
      pause_input();
      push_record(plan[i].rec, plan[i].pinned, plan[i].want);
    end
    settle();

    program_regs('0, FIELD_W'(255), FIELD_W'(0));
    run_phase(450);
    settle();
    program_regs(FIELD_W'($urandom_range(0, 2000)), FIELD_W'($urandom), FIELD_W'($urandom));
    run_phase(450);
    settle();
    program_regs(M31, FIELD_W'(0), FIELD_W'(255));
    run_phase(150);
    settle();
    program_regs(FIELD_W'($urandom), FIELD_W'($urandom_range(0, 255)),
                 FIELD_W'($urandom_range(0, 255)));
    run_phase(400);
    settle();

    $display("covered %0d record transfers; %0d segments checked,", n_xfer, n_checked);
    $display("%0d on minus strand, %0d with end mismatch, %0d register settings",
             n_minus, n_flagged, n_cfg);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("timeout with %0d segments still pending", segments.size());
    $display("status: fail");
    $finish;
  end

endmodule
